// ===== hdl/fssc_pkg.sv =====
// ---------------------------------------------------------------------------
// fssc_pkg
// shared types and constants of the floppy soft switch controller
// ---------------------------------------------------------------------------
package fssc_pkg;

	localparam int unsigned DRIVES         = 2;
	localparam int unsigned HT_W           = 7;
	localparam int unsigned MAX_HALF_TRACK = 68;
	localparam int unsigned TRACK_W        = 6;
	localparam int unsigned APB_ADDR_W     = 3;
	localparam int unsigned APB_DATA_W     = 32;

	typedef enum logic [1:0] {
		OP_READ  = 2'd0,
		OP_WRITE = 2'd1,
		OP_TICK  = 2'd2
	} op_t;

	// soft switch numbers, low address nibble
	localparam logic [3:0] SW_MOTOR_OFF  = 4'h8;
	localparam logic [3:0] SW_MOTOR_ON   = 4'h9;
	localparam logic [3:0] SW_DRIVE0     = 4'hA;
	localparam logic [3:0] SW_DRIVE1     = 4'hB;
	localparam logic [3:0] SW_STROBE     = 4'hC;
	localparam logic [3:0] SW_LOAD       = 4'hD;
	localparam logic [3:0] SW_READ_MODE  = 4'hE;
	localparam logic [3:0] SW_WRITE_MODE = 4'hF;

	// register index, taken from paddr[2]
	localparam logic REG_FAST_MODE     = 1'b0;
	localparam logic REG_DRIVE_PRESENT = 1'b1;

	localparam logic [7:0] BYTE_IDLE    = 8'hFF;
	localparam logic [7:0] BYTE_PROTECT = 8'h80;

	typedef struct packed {
		logic                  fast_mode;
		logic [DRIVES-1:0]     drive_present;
	} cfg_t;

	typedef struct packed {
		op_t        op;
		logic [3:0] address;
		logic [7:0] write_value;
		logic [7:0] drive_byte;
		logic       protect_bit;
		logic [7:0] noise_byte;
	} req_t;

	typedef struct packed {
		logic [7:0]         read_data;
		logic               seek_valid;
		logic [TRACK_W-1:0] seek_track;
		logic               drive_sel;
		logic               byte_write;
		logic [7:0]         write_byte;
		logic               write_kind;
		logic               advance;
		logic               motor;
	} rsp_t;

endpackage

// ===== hdl/fssc_if.sv =====
// ---------------------------------------------------------------------------
// fssc request and result channels
// valid/ready channels carrying one request or one result
// ---------------------------------------------------------------------------
interface fssc_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] op;
	logic [3:0] address;
	logic [7:0] write_value;
	logic [7:0] drive_byte;
	logic       protect_bit;
	logic [7:0] noise_byte;

	modport source (
		output valid, op, address, write_value, drive_byte, protect_bit, noise_byte,
		input  ready
	);
	modport sink (
		input  valid, op, address, write_value, drive_byte, protect_bit, noise_byte,
		output ready
	);
endinterface

interface fssc_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;
	logic       seek_valid;
	logic [5:0] seek_track;
	logic       drive_sel;
	logic       byte_write;
	logic [7:0] write_byte;
	logic       write_kind;
	logic       advance;
	logic       motor;

	modport source (
		output valid, read_data, seek_valid, seek_track, drive_sel, byte_write,
		       write_byte, write_kind, advance, motor,
		input  ready
	);
	modport sink (
		input  valid, read_data, seek_valid, seek_track, drive_sel, byte_write,
		       write_byte, write_kind, advance, motor,
		output ready
	);
endinterface

// ===== hdl/fssc_apb_regs.sv =====
// ---------------------------------------------------------------------------
// fssc_apb_regs
// configuration registers behind an apb-style port
// ---------------------------------------------------------------------------
module fssc_apb_regs
	import fssc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output cfg_t                  cfg
);

	logic              fast_mode_q;
	logic [DRIVES-1:0] drive_present_q;
	logic              wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fast_mode_q     <= 1'b1;
			drive_present_q <= '1;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_FAST_MODE:     fast_mode_q     <= pwdata[0];
				REG_DRIVE_PRESENT: drive_present_q <= pwdata[DRIVES-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr[2])
			REG_FAST_MODE:     prdata[0]          = fast_mode_q;
			REG_DRIVE_PRESENT: prdata[DRIVES-1:0] = drive_present_q;
			default: ;
		endcase
	end

	assign cfg.fast_mode     = fast_mode_q;
	assign cfg.drive_present = drive_present_q;

endmodule

// ===== hdl/fssc_engine.sv =====
// ---------------------------------------------------------------------------
// fssc_engine
// soft switch decode, head stepper, latches and controller state
// ---------------------------------------------------------------------------
module fssc_engine
	import fssc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic step,
	input  req_t item,
	input  cfg_t cfg,
	output rsp_t result
);

	logic [1:0]      last_phase_q, last_phase_d;
	logic            phase_valid_q, phase_valid_d;
	logic [HT_W-1:0] half_track_q [DRIVES];
	logic [HT_W-1:0] ht_cur, ht_d;
	logic            motor_q, motor_d;
	logic            writing_q, writing_d;
	logic            drive_q, drive_d;
	logic [7:0]      write_latch_q, write_latch_d;
	logic [7:0]      read_latch_q, read_latch_d;
	logic            latch_ready_q, latch_ready_d;

	logic       present;
	logic       strobe;
	logic       moved;
	logic [1:0] phase_n;

	assign present = cfg.drive_present[drive_q];
	assign ht_cur  = half_track_q[drive_q];
	assign phase_n = item.address[2:1];

	always_comb begin
		last_phase_d  = last_phase_q;
		phase_valid_d = phase_valid_q;
		ht_d          = ht_cur;
		motor_d       = motor_q;
		writing_d     = writing_q;
		drive_d       = drive_q;
		write_latch_d = write_latch_q;
		read_latch_d  = read_latch_q;
		latch_ready_d = latch_ready_q;
		strobe        = 1'b0;
		moved         = 1'b0;
		result        = '0;
		result.read_data = BYTE_IDLE;

		unique case (item.op) inside
			OP_READ, OP_WRITE: begin
				if (!item.address[3]) begin
					// odd switches energise a phase
					if (item.address[0]) begin
						if (phase_valid_q) begin
							if (phase_n == last_phase_q - 2'd1) begin
								if (ht_cur != '0) begin
									ht_d  = ht_cur - HT_W'(1);
									moved = 1'b1;
								end
							end else if (phase_n == last_phase_q + 2'd1) begin
								if (ht_cur < HT_W'(MAX_HALF_TRACK)) begin
									ht_d  = ht_cur + HT_W'(1);
									moved = 1'b1;
								end
							end
						end
						last_phase_d  = phase_n;
						phase_valid_d = 1'b1;
					end
				end else if (item.address == SW_DRIVE0 || item.address == SW_DRIVE1) begin
					drive_d = item.address[0];
				end else if (item.op == OP_READ) begin
					case (item.address)
						SW_MOTOR_OFF: motor_d = 1'b0;
						SW_MOTOR_ON:  motor_d = 1'b1;
						SW_STROBE: begin
							if (writing_q) begin
								strobe = 1'b1;
							end else if (!motor_q) begin
								result.read_data = item.noise_byte;
							end else if (cfg.fast_mode) begin
								if (present) begin
									result.read_data = item.drive_byte;
									result.advance   = 1'b1;
								end
							end else if (latch_ready_q) begin
								latch_ready_d    = 1'b0;
								result.read_data = read_latch_q;
							end else begin
								result.read_data = '0;
							end
						end
						SW_READ_MODE: begin
							writing_d = 1'b0;
							if (present) begin
								result.read_data = item.protect_bit ? BYTE_PROTECT : 8'h00;
							end
						end
						SW_WRITE_MODE: writing_d = 1'b1;
						default: ;
					endcase
				end else begin
					case (item.address)
						SW_STROBE: begin
							strobe        = 1'b1;
							write_latch_d = item.write_value;
						end
						SW_LOAD:       write_latch_d = item.write_value;
						SW_READ_MODE:  writing_d     = 1'b0;
						SW_WRITE_MODE: begin
							writing_d     = 1'b1;
							write_latch_d = item.write_value;
						end
						default: ;
					endcase
				end
			end
			OP_TICK: begin
				// syncro mode: byte timer latches the next byte, or advances when writing
				if (!cfg.fast_mode && motor_q) begin
					if (writing_q) begin
						result.advance = present;
					end else begin
						latch_ready_d = 1'b1;
						if (present) begin
							read_latch_d   = item.drive_byte;
							result.advance = 1'b1;
						end else begin
							read_latch_d = BYTE_IDLE;
						end
					end
				end
			end
			default: ;
		endcase

		if (moved && present) begin
			result.seek_valid = 1'b1;
			result.seek_track = ht_d[HT_W-1:1];
		end

		if (strobe && motor_q && present) begin
			result.byte_write = 1'b1;
			result.write_byte = write_latch_q;
			result.write_kind = !cfg.fast_mode;
			result.advance    = cfg.fast_mode;
		end

		result.drive_sel = drive_d;
		result.motor     = motor_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_phase_q  <= '0;
			phase_valid_q <= 1'b0;
			for (int i = 0; i < DRIVES; i++) begin
				half_track_q[i] <= '0;
			end
			motor_q       <= 1'b0;
			writing_q     <= 1'b0;
			drive_q       <= 1'b0;
			write_latch_q <= '0;
			read_latch_q  <= '0;
			latch_ready_q <= 1'b0;
		end else if (step) begin
			last_phase_q           <= last_phase_d;
			phase_valid_q          <= phase_valid_d;
			half_track_q[drive_q]  <= ht_d;
			motor_q                <= motor_d;
			writing_q              <= writing_d;
			drive_q                <= drive_d;
			write_latch_q          <= write_latch_d;
			read_latch_q           <= read_latch_d;
			latch_ready_q          <= latch_ready_d;
		end
	end

endmodule

// ===== hdl/floppy_soft_switch_controller.sv =====
// ---------------------------------------------------------------------------
// floppy_soft_switch_controller
// floppy controller decoded as sixteen soft switches
// ---------------------------------------------------------------------------
// a request passes through the input register, then the result register
// throughput: one request per cycle while the result side is not stalled
// a stalled result still lets one more request into the input register
// reset: arst_n clears engine state, valid flags; fast_mode 1, drive_present 3
module floppy_soft_switch_controller
	import fssc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	fssc_req_if.sink              req,
	fssc_rsp_if.source            rsp,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	cfg_t cfg;
	req_t item_s1;
	logic valid_s1;
	rsp_t result;
	rsp_t rsp_q;
	logic rsp_valid_q;
	logic out_free;
	logic step;

	fssc_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign out_free  = !rsp_valid_q || rsp.ready;
	assign step      = valid_s1 && out_free;
	assign req.ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.valid && req.ready) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1.op          <= op_t'(req.op);
			item_s1.address     <= req.address;
			item_s1.write_value <= req.write_value;
			item_s1.drive_byte  <= req.drive_byte;
			item_s1.protect_bit <= req.protect_bit;
			item_s1.noise_byte  <= req.noise_byte;
		end
	end

	fssc_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.cfg    (cfg),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (step) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			rsp_q <= result;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.read_data  = rsp_q.read_data;
	assign rsp.seek_valid = rsp_q.seek_valid;
	assign rsp.seek_track = rsp_q.seek_track;
	assign rsp.drive_sel  = rsp_q.drive_sel;
	assign rsp.byte_write = rsp_q.byte_write;
	assign rsp.write_byte = rsp_q.write_byte;
	assign rsp.write_kind = rsp_q.write_kind;
	assign rsp.advance    = rsp_q.advance;
	assign rsp.motor      = rsp_q.motor;

endmodule

// ===== hdl/fssc_checker.sv =====
// ---------------------------------------------------------------------------
// fssc_checker
// port-level checks on the result channel of the controller
// ---------------------------------------------------------------------------
module fssc_checker
	import fssc_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               rsp_valid,
	input logic               rsp_ready,
	input logic [7:0]         read_data,
	input logic               seek_valid,
	input logic [TRACK_W-1:0] seek_track,
	input logic               byte_write,
	input logic [7:0]         write_byte,
	input logic               write_kind,
	input logic               advance
);

	// stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=>
			rsp_valid && $stable(read_data) && $stable(seek_track) && $stable(write_byte))
		else $error("result changed while stalled");

	a_track_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && seek_valid |-> seek_track <= TRACK_W'(MAX_HALF_TRACK / 2))
		else $error("seek beyond last track");

	a_no_seek_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !seek_valid |-> seek_track == '0)
		else $error("track reported without a seek");

	// write and advance, or write in place, never both
	a_write_kind: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && byte_write |-> advance != write_kind)
		else $error("byte write with inconsistent kind");

	a_no_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !byte_write |-> write_byte == '0 && !write_kind)
		else $error("write fields set without a byte write");

endmodule

bind floppy_soft_switch_controller fssc_checker u_fssc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.read_data  (rsp.read_data),
	.seek_valid (rsp.seek_valid),
	.seek_track (rsp.seek_track),
	.byte_write (rsp.byte_write),
	.write_byte (rsp.write_byte),
	.write_kind (rsp.write_kind),
	.advance    (rsp.advance)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the floppy soft switch controller. A table of
// directed requests runs first. Random phases follow: seek sweeps, read and
// write sessions, and noise, each phase under its own register setting. An
// in-bench model of the switches predicts every result but those of typed
// table rows, and the result stream is checked field by field in order.
// ---------------------------------------------------------------------------
module tb_top;
	import fssc_pkg::*;

	localparam logic [1:0] OP_SPARE   = 2'd3;
	localparam logic [3:0] SW_PH0_OFF = 4'h0;
	localparam logic [3:0] SW_PH0_ON  = 4'h1;
	localparam logic [3:0] SW_PH1_ON  = 4'h3;
	localparam logic [3:0] SW_PH2_ON  = 4'h5;
	localparam logic [3:0] SW_PH3_ON  = 4'h7;

	localparam int DIR_N           = 25;
	localparam int PHASES          = 9;
	localparam int ITEMS_PER_PHASE = 188;
	localparam int QUIET_LIMIT     = 2000;
	localparam int HOLD_CYCLES     = 250;
	localparam logic [PHASES-1:0]   FAST_PLAN    = 9'b010101001;
	localparam logic [2*PHASES-1:0] PRESENT_PLAN = 18'b11_10_01_00_10_01_00_11_11;

	typedef struct packed {
		logic [1:0] op;
		logic [3:0] address;
		logic [7:0] write_value;
		logic [7:0] drive_byte;
		logic       protect_bit;
		logic [7:0] noise_byte;
		logic       typed;
		logic [7:0] typed_rd;
	} sw_item_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite, pready;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata, prdata;

	fssc_req_if req_ch();
	fssc_rsp_if rsp_ch();

	floppy_soft_switch_controller dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// switch model state
	logic       m_fast;
	logic [1:0] m_present;
	logic [1:0] last_ph;
	logic       ph_ok;
	logic [6:0] half_trk [DRIVES];
	logic       motor_run, wr_mode, cur_drv;
	logic [7:0] wr_latch, rd_latch;
	logic       rd_full;

	sw_item_t dir_tab [DIR_N];
	sw_item_t stim_q [$];
	sw_item_t offered_q [$];
	rsp_t     due_results [$];

	int  fail_count;
	int  results_seen;
	int  quiet_cycles;
	int  hold_asks, hold_seen, hold_left;
	bit  calm;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic rsp_t strobe_latch(input rsp_t r);
		rsp_t o;
		o = r;
		if (motor_run && m_present[cur_drv]) begin
			o.byte_write = 1'b1;
			o.write_byte = wr_latch;
			o.write_kind = !m_fast;
			o.advance    = m_fast;
		end
		return o;
	endfunction

	function automatic rsp_t step_switches(input sw_item_t a);
		rsp_t       r;
		logic       here;
		logic [1:0] n;
		logic       moved;
		r = '0;
		r.read_data = BYTE_IDLE;
		here = m_present[cur_drv];
		moved = 1'b0;
		n = a.address[2:1];
		if (a.op == OP_READ || a.op == OP_WRITE) begin
			if (!a.address[3]) begin
				if (a.address[0]) begin
					if (ph_ok) begin
						if (n == last_ph - 2'd1) begin
							if (half_trk[cur_drv] != 7'd0) begin
								half_trk[cur_drv] = half_trk[cur_drv] - 7'd1;
								moved = 1'b1;
							end
						end else if (n == last_ph + 2'd1) begin
							if (half_trk[cur_drv] < MAX_HALF_TRACK) begin
								half_trk[cur_drv] = half_trk[cur_drv] + 7'd1;
								moved = 1'b1;
							end
						end
						if (moved && here) begin
							r.seek_valid = 1'b1;
							r.seek_track = half_trk[cur_drv][6:1];
						end
					end
					last_ph = n;
					ph_ok = 1'b1;
				end
			end else if (a.address == SW_DRIVE0 || a.address == SW_DRIVE1) begin
				cur_drv = a.address[0];
			end else if (a.op == OP_READ) begin
				case (a.address)
					SW_MOTOR_OFF: motor_run = 1'b0;
					SW_MOTOR_ON: motor_run = 1'b1;
					SW_STROBE: begin
						if (wr_mode) begin
							r = strobe_latch(r);
						end else if (!motor_run) begin
							r.read_data = a.noise_byte;
						end else if (m_fast) begin
							if (here) begin
								r.read_data = a.drive_byte;
								r.advance = 1'b1;
							end
						end else if (rd_full) begin
							rd_full = 1'b0;
							r.read_data = rd_latch;
						end else begin
							r.read_data = 8'h00;
						end
					end
					SW_READ_MODE: begin
						wr_mode = 1'b0;
						if (here) r.read_data = a.protect_bit ? BYTE_PROTECT : 8'h00;
					end
					SW_WRITE_MODE: wr_mode = 1'b1;
					default: ;
				endcase
			end else begin
				case (a.address)
					SW_STROBE: begin
						r = strobe_latch(r);
						wr_latch = a.write_value;
					end
					SW_LOAD: wr_latch = a.write_value;
					SW_READ_MODE: wr_mode = 1'b0;
					SW_WRITE_MODE: begin
						wr_mode = 1'b1;
						wr_latch = a.write_value;
					end
					default: ;
				endcase
			end
		end else if (a.op == OP_TICK) begin
			if (!m_fast && motor_run) begin
				if (wr_mode) begin
					if (here) r.advance = 1'b1;
				end else begin
					rd_full = 1'b1;
					if (here) begin
						rd_latch = a.drive_byte;
						r.advance = 1'b1;
					end else begin
						rd_latch = BYTE_IDLE;
					end
				end
			end
		end
		r.drive_sel = cur_drv;
		r.motor = motor_run;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		if (fail_count < 40)
			$display("%0t: result %0d %s: got %0h, want %0h", $time, results_seen, what, got, want);
		fail_count++;
	endtask

	// result checking, then prediction of the request accepted at this edge
	always @(posedge clk) begin
		rsp_t     got, want;
		sw_item_t it;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				got.read_data  = rsp_ch.read_data;
				got.seek_valid = rsp_ch.seek_valid;
				got.seek_track = rsp_ch.seek_track;
				got.drive_sel  = rsp_ch.drive_sel;
				got.byte_write = rsp_ch.byte_write;
				got.write_byte = rsp_ch.write_byte;
				got.write_kind = rsp_ch.write_kind;
				got.advance    = rsp_ch.advance;
				got.motor      = rsp_ch.motor;
				if (due_results.size() == 0) begin
					report_mismatch("with no request pending", int'(got), 0);
				end else begin
					want = due_results.pop_front();
					if (got.read_data != want.read_data)
						report_mismatch("read_data",
							int'(got.read_data), int'(want.read_data));
					if (got.seek_valid != want.seek_valid)
						report_mismatch("seek_valid",
							int'(got.seek_valid), int'(want.seek_valid));
					if (got.seek_track != want.seek_track)
						report_mismatch("seek_track",
							int'(got.seek_track), int'(want.seek_track));
					if (got.drive_sel != want.drive_sel)
						report_mismatch("drive_sel",
							int'(got.drive_sel), int'(want.drive_sel));
					if (got.byte_write != want.byte_write)
						report_mismatch("byte_write",
							int'(got.byte_write), int'(want.byte_write));
					if (got.write_byte != want.write_byte)
						report_mismatch("write_byte",
							int'(got.write_byte), int'(want.write_byte));
					if (got.write_kind != want.write_kind)
						report_mismatch("write_kind",
							int'(got.write_kind), int'(want.write_kind));
					if (got.advance != want.advance)
						report_mismatch("advance",
							int'(got.advance), int'(want.advance));
					if (got.motor != want.motor)
						report_mismatch("motor", int'(got.motor), int'(want.motor));
				end
				results_seen++;
			end
			if (req_ch.valid && req_ch.ready) begin
				it = offered_q.pop_front();
				it.op          = req_ch.op;
				it.address     = req_ch.address;
				it.write_value = req_ch.write_value;
				it.drive_byte  = req_ch.drive_byte;
				it.protect_bit = req_ch.protect_bit;
				it.noise_byte  = req_ch.noise_byte;
				want = step_switches(it);
				if (it.typed) begin
					want = '0;
					want.read_data = it.typed_rd;
				end
				due_results = {due_results, want};
			end
		end
	end

	// result side: random stalls, one long hold on request
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			rsp_ch.ready <= 1'b0;
		end else if (hold_seen != hold_asks) begin
			hold_seen = hold_asks;
			hold_left = HOLD_CYCLES;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= calm || ($urandom_range(0, 99) >= 16);
		end
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("[floppy_soft_switch_controller] ERROR");
			$finish;
		end
	end

	function automatic sw_item_t any_access();
		sw_item_t it;
		it = '0;
		it.op          = ($urandom_range(0, 63) == 0) ? OP_SPARE : 2'($urandom_range(0, 2));
		it.address     = 4'($urandom_range(0, 15));
		it.write_value = 8'($urandom_range(0, 255));
		it.drive_byte  = 8'($urandom_range(0, 255));
		it.protect_bit = 1'($urandom_range(0, 1));
		it.noise_byte  = 8'($urandom_range(0, 255));
		return it;
	endfunction

	function automatic sw_item_t access_to(input logic [1:0] op, input logic [3:0] address);
		sw_item_t it;
		it = any_access();
		it.op = op;
		it.address = address;
		return it;
	endfunction

	function automatic logic [3:0] any_drive();
		return $urandom_range(0, 1) ? SW_DRIVE1 : SW_DRIVE0;
	endfunction

	task automatic add_stim(input sw_item_t it);
		stim_q = {stim_q, it};
	endtask

	task automatic plan_traffic(input int count);
		int         kind, n, r;
		logic [1:0] ph;
		bit         up;
		while (stim_q.size() < count) begin
			kind = $urandom_range(0, 9);
			if (kind < 2) begin
				n = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 90) : $urandom_range(2, 8);
				up = 1'($urandom_range(0, 1));
				ph = 2'($urandom_range(0, 3));
				repeat (n) begin
					if ($urandom_range(0, 15) == 0) begin
						add_stim(access_to(2'($urandom_range(0, 1)), any_drive()));
					end else begin
						ph = up ? ph + 2'd1 : ph - 2'd1;
						add_stim(access_to(2'($urandom_range(0, 1)), {1'b0, ph, 1'b1}));
					end
				end
			end else if (kind < 4) begin
				add_stim(access_to(OP_READ, SW_MOTOR_ON));
				add_stim(access_to(OP_READ, SW_READ_MODE));
				repeat ($urandom_range(4, 30)) begin
					r = $urandom_range(0, 9);
					if (r < 5)
						add_stim(access_to(OP_TICK, 4'($urandom_range(0, 15))));
					else if (r < 9)
						add_stim(access_to(OP_READ, SW_STROBE));
					else
						add_stim(access_to(OP_READ, any_drive()));
				end
				if ($urandom_range(0, 1))
					add_stim(access_to(OP_READ, SW_MOTOR_OFF));
			end else if (kind < 6) begin
				add_stim(access_to(OP_READ, SW_MOTOR_ON));
				add_stim(access_to(OP_WRITE, SW_WRITE_MODE));
				repeat ($urandom_range(4, 30)) begin
					r = $urandom_range(0, 9);
					if (r < 3)
						add_stim(access_to(OP_WRITE, SW_STROBE));
					else if (r < 5)
						add_stim(access_to(OP_WRITE, SW_LOAD));
					else if (r < 7)
						add_stim(access_to(OP_READ, SW_STROBE));
					else if (r < 9)
						add_stim(access_to(OP_TICK, 4'($urandom_range(0, 15))));
					else
						add_stim(access_to(2'($urandom_range(0, 1)), any_drive()));
				end
				add_stim(access_to(2'($urandom_range(0, 1)), SW_READ_MODE));
			end else if (kind == 6) begin
				add_stim(access_to(2'($urandom_range(0, 1)), any_drive()));
				add_stim(access_to(OP_READ, SW_READ_MODE));
				add_stim(access_to(OP_READ, SW_STROBE));
			end else begin
				repeat ($urandom_range(1, 12))
					add_stim(any_access());
			end
		end
	endtask

	task automatic send_requests();
		sw_item_t it;
		while (stim_q.size() != 0) begin
			if (!calm && $urandom_range(0, 99) < 16) begin
				req_ch.valid <= 1'b0;
				@(posedge clk);
			end else begin
				it = stim_q.pop_front();
				offered_q = {offered_q, it};
				req_ch.valid       <= 1'b1;
				req_ch.op          <= it.op;
				req_ch.address     <= it.address;
				req_ch.write_value <= it.write_value;
				req_ch.drive_byte  <= it.drive_byte;
				req_ch.protect_bit <= it.protect_bit;
				req_ch.noise_byte  <= it.noise_byte;
				@(posedge clk);
				while (!req_ch.ready) @(posedge clk);
			end
		end
		req_ch.valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (offered_q.size() + due_results.size() != 0) @(posedge clk);
	endtask

	task automatic apb_write(input logic idx, input logic [APB_DATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (idx == REG_FAST_MODE)
			m_fast = value[0];
		else
			m_present = value[1:0];
		@(posedge clk);
	endtask

	initial begin
		int ph;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_ch.valid = 1'b0;
		req_ch.op = OP_READ;
		req_ch.address = '0;
		req_ch.write_value = '0;
		req_ch.drive_byte = '0;
		req_ch.protect_bit = 1'b0;
		req_ch.noise_byte = '0;
		rsp_ch.ready = 1'b0;
		m_fast = 1'b1;
		m_present = 2'b11;
		last_ph = '0;
		ph_ok = 1'b0;
		half_trk[0] = '0;
		half_trk[1] = '0;
		motor_run = 1'b0;
		wr_mode = 1'b0;
		cur_drv = 1'b0;
		wr_latch = '0;
		rd_latch = '0;
		rd_full = 1'b0;
		fail_count = 0;
		results_seen = 0;
		quiet_cycles = 0;
		hold_asks = 0;
		hold_seen = 0;
		hold_left = 0;
		calm = 1'b0;

		// op, switch, write value, drive byte, protect, noise, typed, read data
		dir_tab = '{
			{OP_READ,  SW_READ_MODE,  8'h00, 8'h00, 1'b1, 8'h00, 1'b1, BYTE_PROTECT},
			{OP_READ,  SW_READ_MODE,  8'hFF, 8'hFF, 1'b0, 8'hFF, 1'b1, 8'h00},
			{OP_READ,  SW_STROBE,     8'h00, 8'h00, 1'b0, 8'hFF, 1'b1, 8'hFF},
			{OP_READ,  SW_STROBE,     8'hFF, 8'hFF, 1'b1, 8'h00, 1'b1, 8'h00},
			{OP_SPARE, SW_WRITE_MODE, 8'hFF, 8'hFF, 1'b1, 8'hFF, 1'b1, BYTE_IDLE},
			{OP_WRITE, SW_PH0_ON,     8'h5A, 8'hA5, 1'b0, 8'h5A, 1'b1, BYTE_IDLE},
			{OP_READ,  SW_PH1_ON,     8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00},
			{OP_WRITE, SW_PH2_ON,     8'hFF, 8'h00, 1'b1, 8'h00, 1'b0, 8'h00},
			{OP_READ,  SW_PH0_ON,     8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00},
			{OP_READ,  SW_PH3_ON,     8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00},
			{OP_READ,  SW_DRIVE1,     8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00},
			{OP_WRITE, SW_PH0_ON,     8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00},
			{OP_WRITE, SW_DRIVE0,     8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00},
			{OP_READ,  SW_PH0_OFF,    8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00},
			{OP_READ,  SW_MOTOR_ON,   8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00},
			{OP_READ,  SW_STROBE,     8'h00, 8'h5A, 1'b0, 8'hC3, 1'b0, 8'h00},
			{OP_TICK,  SW_STROBE,     8'h00, 8'hFF, 1'b0, 8'h00, 1'b0, 8'h00},
			{OP_WRITE, SW_LOAD,       8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00},
			{OP_WRITE, SW_STROBE,     8'hFF, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00},
			{OP_READ,  SW_WRITE_MODE, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00},
			{OP_READ,  SW_STROBE,     8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00},
			{OP_WRITE, SW_WRITE_MODE, 8'h3C, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00},
			{OP_WRITE, SW_READ_MODE,  8'h00, 8'h00, 1'b1, 8'h00, 1'b0, 8'h00},
			{OP_WRITE, SW_MOTOR_OFF,  8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00},
			{OP_READ,  SW_MOTOR_OFF,  8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00}
		};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_N; i++)
			add_stim(dir_tab[i]);
		send_requests();

		for (ph = 0; ph < PHASES; ph++) begin
			wait_drained();
			apb_write(REG_FAST_MODE, {31'd0, FAST_PLAN[ph]});
			apb_write(REG_DRIVE_PRESENT, {30'd0, PRESENT_PLAN[2*ph +: 2]});
			calm = (ph == 3);
			// long result stall so the request side backs up
			if (ph == 1) hold_asks++;
			plan_traffic(ITEMS_PER_PHASE);
			send_requests();
		end

		wait_drained();
		repeat (4) @(posedge clk);
		if (fail_count == 0)
			$display("[floppy_soft_switch_controller] OK");
		else
			$display("[floppy_soft_switch_controller] ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/fssc_pkg.sv
hdl/fssc_if.sv
hdl/fssc_apb_regs.sv
hdl/fssc_engine.sv
hdl/floppy_soft_switch_controller.sv
hdl/fssc_checker.sv
tb/tb_top.sv
